FILE: hdl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Phase codes, parser state, character constants and pattern tables shared by
// the response length parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [4:0] STATUS_LEN = 5'd6;
	localparam logic [4:0] HEADER_LEN = 5'd16;
	localparam logic [4:0] DELIM_LEN  = 5'd4;

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UC_A = 8'h41;
	localparam logic [7:0] CH_UC_Z = 8'h5a;

	typedef enum logic [3:0] {
		PH_STATUS = 4'd0,
		PH_HEADER = 4'd1,
		PH_DIGITS = 4'd2,
		PH_LF     = 4'd3,
		PH_LINE2  = 4'd4,
		PH_LAST   = 4'd5,
		PH_DELIM  = 4'd6,
		PH_DONE   = 4'd7,
		PH_ERROR  = 4'd8
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [4:0] pos;
	} parse_state_t;

	function automatic logic [7:0] fold_lc(input logic [7:0] c);
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	// Pattern tables, already folded to lower case.
	function automatic logic [7:0] status_char(input logic [2:0] idx);
		unique case (idx)
			3'd0: return "2";
			3'd1: return "0";
			3'd2: return "0";
			3'd3: return " ";
			3'd4: return "o";
			3'd5: return "k";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] header_char(input logic [3:0] idx);
		unique case (idx)
			4'd0:  return "c";
			4'd1:  return "o";
			4'd2:  return "n";
			4'd3:  return "t";
			4'd4:  return "e";
			4'd5:  return "n";
			4'd6:  return "t";
			4'd7:  return "-";
			4'd8:  return "l";
			4'd9:  return "e";
			4'd10: return "n";
			4'd11: return "g";
			4'd12: return "t";
			4'd13: return "h";
			4'd14: return ":";
			4'd15: return " ";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] delim_char(input logic [1:0] idx);
		return idx[0] ? CH_LF : CH_CR;
	endfunction

endpackage

FILE: hdl/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Per-byte next-state logic: pattern matchers, digit accumulation with
// saturation, and phase sequencing.
// ----------------------------------------------------------------------------
module hrlp_step #(
	parameter int LENGTH_BITS = hrlp_pkg::LENGTH_BITS_DEF
) (
	input  hrlp_pkg::parse_state_t cur,
	input  logic [LENGTH_BITS-1:0] len_cur,
	input  logic [7:0]             data_byte,
	output hrlp_pkg::parse_state_t nxt,
	output logic [LENGTH_BITS-1:0] len_nxt
);

	localparam int LW = LENGTH_BITS + 4;

	logic [7:0]    folded;
	logic [7:0]    pch;
	logic [4:0]    plen;
	logic          hit;
	logic          last;
	logic [4:0]    pos_m;
	logic          is_digit;
	logic [LW-1:0] ext;
	logic [LW-1:0] prod;
	logic [LENGTH_BITS-1:0] acc_sat;

	assign folded = hrlp_pkg::fold_lc(data_byte);

	always_comb begin
		unique case (cur.phase)
			hrlp_pkg::PH_STATUS: begin
				pch  = hrlp_pkg::status_char(cur.pos[2:0]);
				plen = hrlp_pkg::STATUS_LEN;
			end
			hrlp_pkg::PH_HEADER: begin
				pch  = hrlp_pkg::header_char(cur.pos[3:0]);
				plen = hrlp_pkg::HEADER_LEN;
			end
			default: begin
				pch  = hrlp_pkg::delim_char(cur.pos[1:0]);
				plen = hrlp_pkg::DELIM_LEN;
			end
		endcase
	end

	assign hit   = (cur.pos < plen) && (folded == pch);
	assign last  = (cur.pos == plen - 5'd1);
	assign pos_m = (hit && !last) ? cur.pos + 5'd1 : 5'd0;

	// acc * 10 + digit, overflow shows in the top four bits
	assign is_digit = (data_byte >= hrlp_pkg::CH_ZERO) && (data_byte <= hrlp_pkg::CH_NINE);
	assign ext      = {4'b0000, len_cur};
	assign prod     = (ext << 3) + (ext << 1) + LW'(data_byte[3:0]);
	assign acc_sat  = (prod[LW-1:LENGTH_BITS] != 4'b0000) ? '1 : prod[LENGTH_BITS-1:0];

	always_comb begin
		nxt     = cur;
		len_nxt = len_cur;
		unique case (cur.phase)
			hrlp_pkg::PH_STATUS: begin
				nxt.pos = pos_m;
				if (hit && last) begin
					nxt.phase = hrlp_pkg::PH_HEADER;
				end
			end
			hrlp_pkg::PH_HEADER: begin
				nxt.pos = pos_m;
				if (hit && last) begin
					nxt.phase = hrlp_pkg::PH_DIGITS;
				end
			end
			hrlp_pkg::PH_DIGITS: begin
				priority if (data_byte == hrlp_pkg::CH_CR) begin
					nxt.phase = hrlp_pkg::PH_LF;
				end else if (is_digit) begin
					len_nxt = acc_sat;
				end else begin
					nxt.phase = hrlp_pkg::PH_ERROR;
				end
			end
			hrlp_pkg::PH_LF: begin
				nxt.phase = (data_byte == hrlp_pkg::CH_LF) ? hrlp_pkg::PH_LINE2
				                                           : hrlp_pkg::PH_ERROR;
			end
			hrlp_pkg::PH_LINE2: begin
				nxt.pos   = 5'd0;
				nxt.phase = (data_byte == hrlp_pkg::CH_CR) ? hrlp_pkg::PH_LAST
				                                           : hrlp_pkg::PH_DELIM;
			end
			hrlp_pkg::PH_LAST: begin
				nxt.pos   = 5'd0;
				nxt.phase = (data_byte == hrlp_pkg::CH_LF) ? hrlp_pkg::PH_DONE
				                                           : hrlp_pkg::PH_DELIM;
			end
			hrlp_pkg::PH_DELIM: begin
				nxt.pos = pos_m;
				if (hit && last) begin
					nxt.phase = hrlp_pkg::PH_DONE;
				end
			end
			hrlp_pkg::PH_DONE, hrlp_pkg::PH_ERROR: begin
				nxt = cur;
			end
			default: begin
				nxt.phase = hrlp_pkg::PH_ERROR;
			end
		endcase
	end

endmodule

FILE: hdl/http_response_length_parser_top.sv
// An accepted byte is registered in the input register, its result in the
// result register. Throughput: one byte per cycle unless result_stall holds
// a result; the parser state loops through the matcher and accumulator logic.
// Reset: arst_n clears the phase to status search, the match position and
// the length to zero, and empties the input and result registers.
// ----------------------------------------------------------------------------
// http_response_length_parser_top
// Byte-serial HTTP response parser that extracts the Content-Length value.
// ----------------------------------------------------------------------------
module http_response_length_parser_top #(
	parameter int LENGTH_BITS = hrlp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  phase,
	output logic        finished,
	output logic        failed,
	output logic [31:0] body_length
);

	logic                   v_s1;
	logic [7:0]             byte_s1;
	logic                   v_s2;
	logic [3:0]             phase_s2;
	logic                   finished_s2;
	logic                   failed_s2;
	logic [31:0]            body_length_s2;
	hrlp_pkg::parse_state_t st_q;
	hrlp_pkg::parse_state_t st_d;
	logic [LENGTH_BITS-1:0] len_q;
	logic [LENGTH_BITS-1:0] len_d;
	logic [LENGTH_BITS+31:0] len_wide;
	logic                   adv;
	logic                   fire;

	assign adv        = !v_s2 || !result_stall;
	assign byte_stall = v_s1 && !adv;
	assign fire       = v_s1 && adv;
	assign len_wide   = {32'd0, len_d};

	hrlp_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.cur      (st_q),
		.len_cur  (len_q),
		.data_byte(byte_s1),
		.nxt      (st_d),
		.len_nxt  (len_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!byte_stall) begin
			v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= hrlp_pkg::PH_STATUS;
			st_q.pos   <= 5'd0;
			len_q      <= '0;
			v_s2       <= 1'b0;
		end else begin
			if (fire) begin
				st_q  <= st_d;
				len_q <= len_d;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			phase_s2       <= st_d.phase;
			finished_s2    <= (st_d.phase == hrlp_pkg::PH_DONE) ||
			                  (st_d.phase == hrlp_pkg::PH_ERROR);
			failed_s2      <= (st_d.phase == hrlp_pkg::PH_ERROR);
			body_length_s2 <= len_wide[31:0];
		end
	end

	assign result_valid = v_s2;
	assign phase        = phase_s2;
	assign finished     = finished_s2;
	assign failed       = failed_s2;
	assign body_length  = body_length_s2;

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == hrlp_pkg::PH_DONE |=> st_q.phase == hrlp_pkg::PH_DONE)
		else $error("done phase left");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == hrlp_pkg::PH_ERROR |=> st_q.phase == hrlp_pkg::PH_ERROR)
		else $error("error phase left");

	a_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase != hrlp_pkg::PH_DIGITS |=> $stable(len_q))
		else $error("length changed outside digit phase");

	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == hrlp_pkg::PH_DIGITS || st_q.phase == hrlp_pkg::PH_LAST) |->
		st_q.pos == 5'd0)
		else $error("match position not cleared");

	a_state_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(st_q))
		else $error("parser state moved without a transfer");

endmodule
